[sv/oitc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered ID table compactor package
// Shared constants, request and status codes, and the per-cell control type.
// ----------------------------------------------------------------------------
package oitc_pkg;

    // Default sizing of the table.
    localparam int DEF_CAPACITY = 64;
    localparam int DEF_ID_WIDTH = 16;

    // Compaction groups and their lanes.
    localparam int GROUP   = 8;
    localparam int LANE_W  = 8;
    localparam int LANE_IW = $clog2(GROUP);

    // Fixed result field widths.
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int BASE_W   = 6;
    localparam int SRC_W    = GROUP * LANE_W;
    localparam int LCNT_W   = 4;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD     = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPACT = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTHING   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd5;

    // Command broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_APPEND,
        CELL_KILL,
        CELL_TAG,
        CELL_SQUEEZE,
        CELL_ROTATE
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd cmd;
        logic      sel;
    } t_cell_ctrl;

endpackage
`default_nettype wire

[sv/oitc_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered ID table compactor channels
// Valid/ready interfaces for the command and the response channel.
// ----------------------------------------------------------------------------
interface oitc_cmd_if #(
    parameter int ID_WIDTH = oitc_pkg::DEF_ID_WIDTH
) ();
    logic                       valid;
    logic                       ready;
    logic [oitc_pkg::OP_W-1:0]  operation;
    logic signed [ID_WIDTH:0]   remove_id;

    modport source (output valid, operation, remove_id, input ready);
    modport sink   (input valid, operation, remove_id, output ready);
endinterface

interface oitc_rsp_if #(
    parameter int ID_WIDTH = oitc_pkg::DEF_ID_WIDTH
) ();
    logic                           valid;
    logic                           ready;
    logic [oitc_pkg::STATUS_W-1:0]  status;
    logic [ID_WIDTH-1:0]            new_id;
    logic [oitc_pkg::BASE_W-1:0]    dest_base;
    logic [oitc_pkg::SRC_W-1:0]     source_indices;
    logic [oitc_pkg::LCNT_W-1:0]    lane_count;
    logic                           last;

    modport source (output valid, status, new_id, dest_base, source_indices,
                    lane_count, last, input ready);
    modport sink   (input valid, status, new_id, dest_base, source_indices,
                    lane_count, last, output ready);
endinterface
`default_nettype wire

[sv/oitc_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered ID table compactor cell
// One table slot: stored ID, live and valid flags, and the source index tag.
// ----------------------------------------------------------------------------
module oitc_cell #(
    parameter int ID_WIDTH = oitc_pkg::DEF_ID_WIDTH,
    parameter int IW       = 6
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  oitc_pkg::t_cell_ctrl    i_ctrl,
    input  wire [ID_WIDTH-1:0]      i_key,
    input  wire [IW-1:0]            i_tag,
    input  wire [ID_WIDTH-1:0]      i_up_id,
    input  wire                     i_up_live,
    input  wire                     i_up_vld,
    input  wire [IW-1:0]            i_up_src,
    input  wire                     i_hole_in,
    output logic [ID_WIDTH-1:0]     o_id,
    output logic                    o_live,
    output logic                    o_vld,
    output logic [IW-1:0]           o_src,
    output logic                    o_hole_out,
    output logic                    o_match
);
    import oitc_pkg::*;

    logic [ID_WIDTH-1:0] r_id;
    logic [IW-1:0]       r_src;
    logic                r_live;
    logic                r_vld;

    // A hole is a dead slot inside the used part of the table.
    assign o_hole_out = i_hole_in | (r_vld & ~r_live);
    assign o_match    = r_vld & r_live & (r_id == i_key);

    assign o_id   = r_id;
    assign o_live = r_live;
    assign o_vld  = r_vld;
    assign o_src  = r_src;

    // Flags are control state and are cleared on reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
            r_vld  <= 1'b0;
        end else begin
            unique case (i_ctrl.cmd)
                CELL_APPEND: begin
                    if (i_ctrl.sel) begin
                        r_live <= 1'b1;
                        r_vld  <= 1'b1;
                    end
                end
                CELL_KILL: begin
                    if (o_match) begin
                        r_live <= 1'b0;
                    end
                end
                CELL_SQUEEZE: begin
                    if (o_hole_out) begin
                        r_live <= i_up_live;
                        r_vld  <= i_up_vld;
                    end
                end
                CELL_ROTATE: begin
                    r_live <= i_up_live;
                    r_vld  <= i_up_vld;
                end
                default: begin
                end
            endcase
        end
    end

    // Payload moves with the flags.
    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.cmd)
            CELL_APPEND: begin
                if (i_ctrl.sel) begin
                    r_id <= i_key;
                end
            end
            CELL_TAG: begin
                r_src <= i_tag;
            end
            CELL_SQUEEZE: begin
                if (o_hole_out) begin
                    r_id  <= i_up_id;
                    r_src <= i_up_src;
                end
            end
            CELL_ROTATE: begin
                r_id  <= i_up_id;
                r_src <= i_up_src;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

[sv/ordered_id_table_compactor.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Ordered ID table compactor
// Table of rising entity IDs held in a row of cells, with add, remove and
// compaction into groups of eight source indices.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  i_cmd     in         operation, remove_id
//  o_rsp     out        status, new_id, dest_base, source_indices,
//                       lane_count, last
//
//  An add passes through S_ADD and S_RESP, a remove through S_LOOKUP, S_KILL
//  and S_RESP, before the next request can be taken; the response register
//  loads as the block returns to S_IDLE. A request rejected at acceptance
//  goes straight to S_RESP. A compact passes through S_TAG, then one S_SQUEEZE
//  step per pending removal to squeeze a hole out of the row, then one full
//  rotation of the row in S_SCAN to read the source indices at cell 0.
//  Reset is synchronous and clears the counters and every cell flag.
//  A stalled response register holds the compaction rotation in place.
// ----------------------------------------------------------------------------
module ordered_id_table_compactor #(
    parameter int CAPACITY = oitc_pkg::DEF_CAPACITY,
    parameter int ID_WIDTH = oitc_pkg::DEF_ID_WIDTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    oitc_cmd_if.sink    i_cmd,
    oitc_rsp_if.source  o_rsp
);
    import oitc_pkg::*;

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_LOOKUP,
        S_KILL,
        S_TAG,
        S_SQUEEZE,
        S_SCAN,
        S_RESP
    } t_state;

    t_state                 r_state;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_pending;
    logic [CW-1:0]          r_old;
    logic [CW-1:0]          r_nlive;
    logic [CW-1:0]          r_base;
    logic [ID_WIDTH:0]      r_next_id;
    logic [ID_WIDTH:0]      r_key;
    logic [IW-1:0]          r_step;
    logic [LANE_IW-1:0]     r_lane;
    logic [LANE_W-1:0]      r_lanes [GROUP];
    logic                   r_found;
    logic [STATUS_W-1:0]    r_status;
    logic [ID_WIDTH-1:0]    r_new_id;

    logic                   r_out_valid;
    logic [STATUS_W-1:0]    r_out_status;
    logic [ID_WIDTH-1:0]    r_out_new_id;
    logic [BASE_W-1:0]      r_out_base;
    logic [SRC_W-1:0]       r_out_src;
    logic [LCNT_W-1:0]      r_out_lanes;
    logic                   r_out_last;

    // Cell row wiring.
    t_cell_ctrl             cell_ctrl [CAPACITY];
    t_cell_cmd              cmd;
    logic [ID_WIDTH-1:0]    c_id   [CAPACITY];
    logic [IW-1:0]          c_src  [CAPACITY];
    logic [CAPACITY-1:0]    c_live;
    logic [CAPACITY-1:0]    c_vld;
    logic [CAPACITY-1:0]    hole;
    logic [CAPACITY-1:0]    match;
    logic                   hole_top;

    logic                   full;
    logic                   exhausted;
    logic                   out_free;
    logic                   out_load;
    logic                   gather;
    logic                   grp_done;
    logic                   emit_now;
    logic                   adv;
    logic [LANE_W-1:0]      cur_src;
    logic [SRC_W-1:0]       n_pack;
    logic [LCNT_W-1:0]      n_lcnt;
    logic                   n_last;
    logic [LANE_W-1:0]      old_lane;

    assign full      = (r_count == CW'(CAPACITY));
    assign exhausted = r_next_id[ID_WIDTH];
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign hole_top  = hole[CAPACITY-1];
    assign cur_src   = LANE_W'(c_src[0]);
    assign old_lane  = LANE_W'(r_old);

    // Scan of the compacted row: cell 0 holds compacted slot r_step.
    assign gather   = (CW'(r_step) < r_nlive);
    assign grp_done = (r_lane == LANE_IW'(GROUP - 1)) ||
                      ((CW'(r_step) + CW'(1)) == r_nlive);
    assign emit_now = (r_state == S_SCAN) &&
                      ((gather && grp_done) || ((r_nlive == '0) && (r_step == '0)));
    assign adv      = !emit_now || out_free;
    assign n_lcnt   = gather ? (LCNT_W'(r_lane) + LCNT_W'(1)) : '0;
    assign n_last   = !gather || ((CW'(r_step) + CW'(1)) == r_nlive);

    // The response register takes a new response this cycle.
    assign out_load = out_free && ((r_state == S_RESP) || emit_now);

    // Group being emitted, with the current lane taken from cell 0.
    always_comb begin
        for (int l = 0; l < GROUP; l++) begin
            n_pack[l*LANE_W +: LANE_W] = (gather && (r_lane == LANE_IW'(l))) ?
                                         cur_src : r_lanes[l];
        end
    end

    // Command broadcast to the row.
    always_comb begin
        cmd = CELL_HOLD;
        unique case (r_state)
            S_ADD: begin
                if (!full && !exhausted) begin
                    cmd = CELL_APPEND;
                end
            end
            S_KILL: begin
                if (r_found) begin
                    cmd = CELL_KILL;
                end
            end
            S_TAG: begin
                cmd = CELL_TAG;
            end
            S_SQUEEZE: begin
                if (hole_top) begin
                    cmd = CELL_SQUEEZE;
                end
            end
            S_SCAN: begin
                if (adv) begin
                    cmd = CELL_ROTATE;
                end
            end
            default: begin
                cmd = CELL_HOLD;
            end
        endcase
    end

    // The row of cells; each takes its upper neighbor, the top one wraps.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [ID_WIDTH-1:0] up_id;
        logic [IW-1:0]       up_src;
        logic                up_live;
        logic                up_vld;
        logic                hole_in;

        if (k == CAPACITY - 1) begin : g_top
            assign up_id   = c_id[0];
            assign up_src  = c_src[0];
            assign up_live = (cmd == CELL_ROTATE) && c_live[0];
            assign up_vld  = (cmd == CELL_ROTATE) && c_vld[0];
        end else begin : g_mid
            assign up_id   = c_id[k+1];
            assign up_src  = c_src[k+1];
            assign up_live = c_live[k+1];
            assign up_vld  = c_vld[k+1];
        end

        if (k == 0) begin : g_first
            assign hole_in = 1'b0;
        end else begin : g_rest
            assign hole_in = hole[k-1];
        end

        assign cell_ctrl[k].cmd = cmd;
        assign cell_ctrl[k].sel = (r_count == CW'(k));

        oitc_cell #(
            .ID_WIDTH (ID_WIDTH),
            .IW       (IW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (cell_ctrl[k]),
            .i_key      (r_key[ID_WIDTH-1:0]),
            .i_tag      (IW'(k)),
            .i_up_id    (up_id),
            .i_up_live  (up_live),
            .i_up_vld   (up_vld),
            .i_up_src   (up_src),
            .i_hole_in  (hole_in),
            .o_id       (c_id[k]),
            .o_live     (c_live[k]),
            .o_vld      (c_vld[k]),
            .o_src      (c_src[k]),
            .o_hole_out (hole[k]),
            .o_match    (match[k])
        );
    end

    assign i_cmd.ready = (r_state == S_IDLE);

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.new_id         = r_out_new_id;
    assign o_rsp.dest_base      = r_out_base;
    assign o_rsp.source_indices = r_out_src;
    assign o_rsp.lane_count     = r_out_lanes;
    assign o_rsp.last           = r_out_last;

    // Sequencer, counters and response register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pending   <= '0;
            r_next_id   <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_lane      <= '0;
            r_base      <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        // An add carries the next ID to the row on the key lines.
                        r_key    <= (i_cmd.operation == OP_ADD) ? r_next_id
                                                                : i_cmd.remove_id;
                        r_new_id <= '0;
                        unique case (i_cmd.operation)
                            OP_ADD: begin
                                r_state <= S_ADD;
                            end
                            OP_REMOVE: begin
                                if (&i_cmd.remove_id) begin
                                    r_status <= ST_IGNORED;
                                    r_state  <= S_RESP;
                                end else if (i_cmd.remove_id[ID_WIDTH]) begin
                                    r_status <= ST_NOT_FOUND;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_state <= S_LOOKUP;
                                end
                            end
                            OP_COMPACT: begin
                                if (r_pending == '0) begin
                                    r_status <= ST_NOTHING;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_state <= S_TAG;
                                end
                            end
                            default: begin
                                r_status <= ST_IGNORED;
                                r_state  <= S_RESP;
                            end
                        endcase
                    end
                end
                S_ADD: begin
                    if (full) begin
                        r_status <= ST_FULL;
                    end else if (exhausted) begin
                        r_status <= ST_EXHAUSTED;
                    end else begin
                        r_status  <= ST_OK;
                        r_new_id  <= r_next_id[ID_WIDTH-1:0];
                        r_count   <= r_count + CW'(1);
                        r_next_id <= r_next_id + (ID_WIDTH+1)'(1);
                    end
                    r_state <= S_RESP;
                end
                S_LOOKUP: begin
                    r_found <= |match;
                    r_state <= S_KILL;
                end
                S_KILL: begin
                    if (r_found) begin
                        r_status  <= ST_OK;
                        r_pending <= r_pending + CW'(1);
                    end else begin
                        r_status <= ST_NOT_FOUND;
                    end
                    r_state <= S_RESP;
                end
                S_TAG: begin
                    r_old   <= r_count;
                    r_nlive <= r_count - r_pending;
                    r_state <= S_SQUEEZE;
                end
                S_SQUEEZE: begin
                    if (!hole_top) begin
                        r_count   <= r_nlive;
                        r_pending <= '0;
                        r_step    <= '0;
                        r_lane    <= '0;
                        r_base    <= '0;
                        for (int l = 0; l < GROUP; l++) begin
                            r_lanes[l] <= old_lane;
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (adv) begin
                        if (emit_now) begin
                            r_out_status <= ST_OK;
                            r_out_new_id <= '0;
                            r_out_base   <= BASE_W'(r_base);
                            r_out_src    <= n_pack;
                            r_out_lanes  <= n_lcnt;
                            r_out_last   <= n_last;
                        end
                        if (gather) begin
                            if (grp_done) begin
                                for (int l = 0; l < GROUP; l++) begin
                                    r_lanes[l] <= old_lane;
                                end
                                r_lane <= '0;
                                r_base <= r_base + CW'(GROUP);
                            end else begin
                                r_lanes[r_lane] <= cur_src;
                                r_lane          <= r_lane + LANE_IW'(1);
                            end
                        end
                        r_step <= r_step + IW'(1);
                        if (r_step == IW'(CAPACITY - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_status <= r_status;
                        r_out_new_id <= r_new_id;
                        r_out_base   <= '0;
                        r_out_src    <= '0;
                        r_out_lanes  <= '0;
                        r_out_last   <= 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Pending removals never outnumber the used slots.
    a_pending_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= r_count)
        else $error("pending removals exceed entry count");

    // The entry count never passes the table size.
    a_count_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // Stored IDs rise strictly, so a lookup hits at most one live slot.
    a_unique_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOKUP) |-> $onehot0(match))
        else $error("lookup matched more than one slot");

    // The scan only starts once every hole has been squeezed out.
    a_no_hole_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !hole_top)
        else $error("hole left in the row during scan");

    // An emitted group always lands in the response register.
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_now && out_free) |=> r_out_valid)
        else $error("compaction group lost");

endmodule
`default_nettype wire

[tb/ordered_id_table_compactor_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered ID table compactor testbench
// Drives add, remove and compact requests over the command channel. Each
// request is predicted by a shadow copy of the ID table, and every response
// is compared field by field with the oldest predicted response. A short
// directed table comes first. A random phase with idle gaps and one long
// response stall follows.
// ----------------------------------------------------------------------------
module ordered_id_table_compactor_tb;
    import oitc_pkg::*;

    localparam int CAPACITY       = DEF_CAPACITY;
    localparam int ID_W           = DEF_ID_WIDTH;
    localparam int ID_SPAN        = 1 << ID_W;
    localparam int RANDOM_ITEMS   = 120;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 200;
    localparam int PLAN_LEN       = 25;
    localparam int PRINT_CAP      = 40;

    // The fourth operation code has no meaning and must be ignored.
    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

    // One response as seen on the response channel.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ID_W-1:0]     new_id;
        logic [BASE_W-1:0]   dest_base;
        logic [SRC_W-1:0]    source_indices;
        logic [LCNT_W-1:0]   lane_count;
        logic                last;
    } t_table_rsp;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ID_W:0]       rid;
        int                  reps;
        bit                  typed;
        logic [STATUS_W-1:0] want_status;
        logic [ID_W-1:0]     want_id;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    oitc_cmd_if #(.ID_WIDTH(ID_W)) cmd_if ();
    oitc_rsp_if #(.ID_WIDTH(ID_W)) rsp_if ();

    ordered_id_table_compactor #(
        .CAPACITY(CAPACITY),
        .ID_WIDTH(ID_W)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // Shadow copy of the table.
    logic [ID_W-1:0] shadow_ids [CAPACITY];
    bit              shadow_live [CAPACITY];
    int              shadow_count;
    int              shadow_next;
    int              shadow_pending;

    t_table_rsp due_responses [$];
    int         mismatches  = 0;
    int         quiet_cycles = 0;
    bit         idle_on     = 1'b1;
    bit         hold_req    = 1'b0;

    // Directed table: error codes, extremes, full table and an eight-group compact.
    t_plan_row plan_rows [PLAN_LEN] = '{
        '{OP_COMPACT, 17'sd0,     1,  1'b1, ST_NOTHING,   16'd0},
        '{OP_REMOVE,  17'sh1FFFF, 1,  1'b1, ST_IGNORED,   16'd0},
        '{OP_REMOVE,  17'sd0,     1,  1'b1, ST_NOT_FOUND, 16'd0},
        '{OP_REMOVE,  17'sh1FFFE, 1,  1'b1, ST_NOT_FOUND, 16'd0},
        '{OP_REMOVE,  17'sh10000, 1,  1'b1, ST_NOT_FOUND, 16'd0},
        '{OP_UNDEF,   17'sh1FFFF, 1,  1'b1, ST_IGNORED,   16'd0},
        '{OP_ADD,     17'sh1FFFF, 1,  1'b1, ST_OK,        16'd0},
        '{OP_ADD,     17'sd0,     1,  1'b1, ST_OK,        16'd1},
        '{OP_ADD,     17'sh0FFFF, 1,  1'b1, ST_OK,        16'd2},
        '{OP_REMOVE,  17'sd1,     1,  1'b1, ST_OK,        16'd0},
        '{OP_REMOVE,  17'sd1,     1,  1'b1, ST_NOT_FOUND, 16'd0},
        '{OP_REMOVE,  17'sd65535, 1,  1'b1, ST_NOT_FOUND, 16'd0},
        '{OP_REMOVE,  17'sd5,     1,  1'b1, ST_NOT_FOUND, 16'd0},
        '{OP_COMPACT, 17'sh1FFFF, 1,  1'b0, ST_OK,        16'd0},
        '{OP_REMOVE,  17'sd0,     1,  1'b1, ST_OK,        16'd0},
        '{OP_REMOVE,  17'sd2,     1,  1'b1, ST_OK,        16'd0},
        '{OP_COMPACT, 17'sd0,     1,  1'b0, ST_OK,        16'd0},
        '{OP_ADD,     17'sd0,     64, 1'b0, ST_OK,        16'd0},
        '{OP_ADD,     17'sd0,     1,  1'b1, ST_FULL,      16'd0},
        '{OP_REMOVE,  17'sd3,     1,  1'b1, ST_OK,        16'd0},
        '{OP_REMOVE,  17'sd66,    1,  1'b1, ST_OK,        16'd0},
        '{OP_REMOVE,  17'sd40,    1,  1'b1, ST_OK,        16'd0},
        '{OP_COMPACT, 17'sd0,     1,  1'b0, ST_OK,        16'd0},
        '{OP_REMOVE,  17'sd40,    1,  1'b1, ST_NOT_FOUND, 16'd0},
        '{OP_ADD,     17'sd0,     1,  1'b1, ST_OK,        16'd67}
    };

    // Free-running clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Gap length: mostly short, now and then long.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Applies one request to the shadow table and appends the responses it causes.
    task automatic predict_table_op(input logic [OP_W-1:0] op, input logic [ID_W:0] rid,
                                    ref t_table_rsp dst[$]);
        t_table_rsp r;
        int         hit;
        int         live_src [CAPACITY];
        int         nlive;
        int         groups;
        int         idx;
        int         lanes;
        r      = '0;
        r.last = 1'b1;
        case (op)
            OP_ADD: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (shadow_next >= ID_SPAN) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    shadow_ids[shadow_count]  = shadow_next[ID_W-1:0];
                    shadow_live[shadow_count] = 1'b1;
                    shadow_count++;
                    r.status = ST_OK;
                    r.new_id = shadow_next[ID_W-1:0];
                    shadow_next++;
                end
                dst = {dst, r};
            end
            OP_REMOVE: begin
                r.status = ST_NOT_FOUND;
                if (rid == '1) begin
                    r.status = ST_IGNORED;
                end else if (!rid[ID_W]) begin
                    // Stored IDs are unique, so a plain scan finds the one slot.
                    hit = -1;
                    for (int s = 0; s < shadow_count; s++)
                        if (shadow_ids[s] == rid[ID_W-1:0]) hit = s;
                    if (hit >= 0 && shadow_live[hit]) begin
                        shadow_live[hit] = 1'b0;
                        shadow_pending++;
                        r.status = ST_OK;
                    end
                end
                dst = {dst, r};
            end
            OP_COMPACT: begin
                if (shadow_pending == 0) begin
                    r.status = ST_NOTHING;
                    dst = {dst, r};
                end else begin
                    nlive = 0;
                    for (int s = 0; s < shadow_count; s++) begin
                        if (shadow_live[s]) begin
                            live_src[nlive] = s;
                            nlive++;
                        end
                    end
                    groups = (nlive == 0) ? 1 : (nlive + GROUP - 1) / GROUP;
                    // One response per group; spare lanes carry the old entry count.
                    for (int g = 0; g < groups; g++) begin
                        r           = '0;
                        r.status    = ST_OK;
                        r.dest_base = BASE_W'(g * GROUP);
                        lanes       = 0;
                        for (int lane = 0; lane < GROUP; lane++) begin
                            idx = shadow_count;
                            if (g * GROUP + lane < nlive) begin
                                idx = live_src[g * GROUP + lane];
                                lanes++;
                            end
                            r.source_indices[lane * LANE_W +: LANE_W] = LANE_W'(idx);
                        end
                        r.lane_count = LCNT_W'(lanes);
                        r.last       = (g == groups - 1);
                        dst = {dst, r};
                    end
                    for (int s = 0; s < nlive; s++)
                        shadow_ids[s] = shadow_ids[live_src[s]];
                    for (int s = 0; s < CAPACITY; s++)
                        shadow_live[s] = (s < nlive);
                    shadow_count   = nlive;
                    shadow_pending = 0;
                end
            end
            default: begin
                r.status = ST_IGNORED;
                dst = {dst, r};
            end
        endcase
    endtask

    // Offers one request after an optional gap and waits until it is taken.
    task automatic drive_req(input logic [OP_W-1:0] op, input logic [ID_W:0] rid);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 2) == 0) gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.operation <= op;
        cmd_if.remove_id <= rid;
        @(posedge i_clk);
        while (cmd_if.ready !== 1'b1) @(posedge i_clk);
    endtask

    // Response pacing, including one long hold-off on request.
    initial begin : rsp_pacing
        int stall_left;
        stall_left   = 0;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req     = 1'b0;
                stall_left   = LONG_HOLD - 1;
                rsp_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left   = pick_gap() - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // Response check against the oldest predicted response.
    always @(posedge i_clk) begin : rsp_check
        t_table_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (due_responses.size() == 0) begin
                report_mismatch("unexpected response status", 64'(rsp_if.status), 64'd0);
            end else begin
                want = due_responses.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch("status", 64'(rsp_if.status), 64'(want.status));
                if (rsp_if.new_id !== want.new_id)
                    report_mismatch("new_id", 64'(rsp_if.new_id), 64'(want.new_id));
                if (rsp_if.dest_base !== want.dest_base)
                    report_mismatch("dest_base", 64'(rsp_if.dest_base), 64'(want.dest_base));
                if (rsp_if.source_indices !== want.source_indices)
                    report_mismatch("source_indices", rsp_if.source_indices,
                                    want.source_indices);
                if (rsp_if.lane_count !== want.lane_count)
                    report_mismatch("lane_count", 64'(rsp_if.lane_count),
                                    64'(want.lane_count));
                if (rsp_if.last !== want.last)
                    report_mismatch("last", 64'(rsp_if.last), 64'(want.last));
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a request.
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence.
    initial begin : stimulus
        t_table_rsp      scratch [$];
        t_table_rsp      typed_rsp;
        logic [ID_W:0]   rid;
        logic [OP_W-1:0] op;
        int              pick;
        int              slot;
        cmd_if.valid     = 1'b0;
        cmd_if.operation = OP_ADD;
        cmd_if.remove_id = '0;
        i_rst_n          = 1'b0;
        shadow_count     = 0;
        shadow_next      = 0;
        shadow_pending   = 0;
        foreach (shadow_live[s]) begin
            shadow_live[s] = 1'b0;
            shadow_ids[s]  = '0;
        end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        foreach (plan_rows[k]) begin
            for (int n = 0; n < plan_rows[k].reps; n++) begin
                scratch.delete();
                predict_table_op(plan_rows[k].op, plan_rows[k].rid, scratch);
                if (plan_rows[k].typed) begin
                    typed_rsp        = '0;
                    typed_rsp.status = plan_rows[k].want_status;
                    typed_rsp.new_id = plan_rows[k].want_id;
                    typed_rsp.last   = 1'b1;
                    due_responses    = {due_responses, typed_rsp};
                end else begin
                    due_responses = {due_responses, scratch};
                end
                drive_req(plan_rows[k].op, plan_rows[k].rid);
            end
        end

        // Random mix; most removes target stored IDs so that compacts do real work.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = ((n / 50) % 2) == 0;
            if (n == 30) hold_req = 1'b1;
            rid  = (ID_W + 1)'($urandom_range(0, 2 * ID_SPAN - 1));
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                op = OP_ADD;
            end else if (pick < 80) begin
                op   = OP_REMOVE;
                pick = $urandom_range(0, 9);
                if (pick < 6 && shadow_count > 0) begin
                    slot = $urandom_range(0, shadow_count - 1);
                    rid  = {1'b0, shadow_ids[slot]};
                end else if (pick < 7) begin
                    rid = '1;
                end else if (pick < 8) begin
                    rid[ID_W] = 1'b1;
                end else begin
                    rid[ID_W] = 1'b0;
                end
            end else if (pick < 95) begin
                op = OP_COMPACT;
            end else begin
                op = OP_UNDEF;
            end
            predict_table_op(op, rid, due_responses);
            drive_req(op, rid);
        end

        @(negedge i_clk);
        cmd_if.valid <= 1'b0;
        wait (due_responses.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[sim.f]
sv/oitc_pkg.sv
sv/oitc_if.sv
sv/oitc_cell.sv
sv/ordered_id_table_compactor.sv
tb/ordered_id_table_compactor_tb.sv
